// ===== rtl/core/serial_decimal_setpoint_parser_core_defines.svh =====
// Assertion macros used by the setpoint parser checker.
`ifndef SERIAL_DECIMAL_SETPOINT_PARSER_CORE_DEFINES_SVH
`define SERIAL_DECIMAL_SETPOINT_PARSER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its trigger.
`define SDSP_ASSERT_SAME(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its trigger.
`define SDSP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sdsp_pkg.sv =====
// Constants and character codes for the decimal setpoint parser.
package sdsp_pkg;

    localparam int LINE_CAPACITY = 16;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int LIMIT_W       = 20;
    localparam int MAG_W         = 21;
    localparam int WIDE_W        = MAG_W + 4;

    localparam logic [LEN_W-1:0]   LINE_LAST   = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(120000);
    localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic signed [MAG_W-1:0] t_value;

endpackage

// ===== rtl/core/serial_decimal_setpoint_parser_core.sv =====
// Top level of the serial decimal setpoint parser.
//
//  channel   direction  handshake                        payload
//  rx        in         i_rx_valid / o_rx_ready          i_rx_byte [7:0]
//  target    out        o_target_valid / i_target_ready  o_target_value [20:0] signed
//  cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_target_limit [19:0]
//
// One rx word per cycle unless the output blocks, via the input and result registers.
// The throughput is set by the single parse stage between the input word register
// and the result register; a line terminator word holds in the input register only
// while a result waits untaken, so rx stalls only on a blocked output.
// Reset (synchronous, active low) empties both registers, clears the line and loads
// the limit with 120000 thousandths. Config words are taken only while both
// registers are empty.
module serial_decimal_setpoint_parser_core
    import sdsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_target_valid,
    input  logic                 i_target_ready,
    output t_value               o_target_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LIMIT_W-1:0]   i_cfg_target_limit
);

    // Input word register.
    logic            r_in_valid;
    logic [7:0]      r_in_byte;

    // Line state, evaluated as characters arrive.
    logic [LEN_W-1:0] r_line_length, n_line_length;
    logic             r_is_negative, n_is_negative;
    logic             r_seen_point,  n_seen_point;
    logic [1:0]       r_frac_place,  n_frac_place;
    logic             r_scan_stopped, n_scan_stopped;
    logic [MAG_W-1:0] r_magnitude,   n_magnitude;

    // Result register and limit.
    logic               r_out_valid;
    t_value             r_out_value;
    logic [LIMIT_W-1:0] r_limit;

    logic             is_eol, is_digit, is_dot, is_sign, is_kept;
    logic             emit, out_free, advance;
    logic [3:0]       digit;
    logic [WIDE_W-1:0] int_sum, frac_sum, frac_weight;
    logic [MAG_W-1:0] mag_clamped, lim_ext;
    t_value           emit_value;

    // Classify the held word.
    assign is_eol   = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_dot   = (r_in_byte == CH_DOT);
    assign is_sign  = (r_in_byte == CH_PLUS) || (r_in_byte == CH_MINUS);
    assign is_kept  = is_digit || is_dot || is_sign;
    assign digit    = 4'(r_in_byte - CH_ZERO);

    // A terminator on a non-empty line needs the result register.
    assign emit     = r_in_valid && is_eol && (r_line_length != '0);
    assign out_free = !r_out_valid || i_target_ready;
    assign advance  = r_in_valid && (!emit || out_free);

    assign o_rx_ready  = !r_in_valid || advance;
    assign o_cfg_ready = !r_in_valid && !r_out_valid;

    // Integer digit: magnitude times ten plus digit thousands; fraction: weighted add.
    assign int_sum = ({4'b0, r_magnitude} << 3) + ({4'b0, r_magnitude} << 1)
                   + (WIDE_W'(digit) * WIDE_W'(1000));

    always_comb begin
        case (r_frac_place)
            2'd0:    frac_weight = WIDE_W'(100);
            2'd1:    frac_weight = WIDE_W'(10);
            default: frac_weight = WIDE_W'(1);
        endcase
    end

    assign frac_sum = {4'b0, r_magnitude} + (WIDE_W'(digit) * frac_weight);

    // Clamp the magnitude, then apply the sign; negative zero comes out as zero.
    assign lim_ext     = {1'b0, r_limit};
    assign mag_clamped = (r_magnitude > lim_ext) ? lim_ext : r_magnitude;
    assign emit_value  = r_is_negative ? -t_value'(mag_clamped) : t_value'(mag_clamped);

    always_comb begin
        n_line_length  = r_line_length;
        n_is_negative  = r_is_negative;
        n_seen_point   = r_seen_point;
        n_frac_place   = r_frac_place;
        n_scan_stopped = r_scan_stopped;
        n_magnitude    = r_magnitude;
        if (is_eol) begin
            // Clear after an emitted line; an empty line is already clear.
            n_line_length  = '0;
            n_is_negative  = 1'b0;
            n_seen_point   = 1'b0;
            n_frac_place   = 2'd0;
            n_scan_stopped = 1'b0;
            n_magnitude    = '0;
        end else if (is_kept) begin
            if (r_line_length >= LINE_LAST) begin
                // Full line: drop the word and start over.
                n_line_length  = '0;
                n_is_negative  = 1'b0;
                n_seen_point   = 1'b0;
                n_frac_place   = 2'd0;
                n_scan_stopped = 1'b0;
                n_magnitude    = '0;
            end else begin
                n_line_length = r_line_length + LEN_W'(1);
                if (is_sign) begin
                    if (r_line_length == '0) begin
                        n_is_negative = (r_in_byte == CH_MINUS);
                    end else begin
                        n_scan_stopped = 1'b1;
                    end
                end else if (!r_scan_stopped) begin
                    if (is_dot) begin
                        n_seen_point = 1'b1;
                    end else if (!r_seen_point) begin
                        n_magnitude = (int_sum > WIDE_W'(MAG_MAX)) ? MAG_MAX
                                                                  : int_sum[MAG_W-1:0];
                    end else if (r_frac_place != 2'd3) begin
                        n_magnitude  = (frac_sum > WIDE_W'(MAG_MAX)) ? MAG_MAX
                                                                    : frac_sum[MAG_W-1:0];
                        n_frac_place = r_frac_place + 2'd1;
                    end
                end
            end
        end
    end

    // Hold the incoming word until the parse stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Advance the line state once per consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length  <= '0;
            r_is_negative  <= 1'b0;
            r_seen_point   <= 1'b0;
            r_frac_place   <= 2'd0;
            r_scan_stopped <= 1'b0;
            r_magnitude    <= '0;
        end else if (advance) begin
            r_line_length  <= n_line_length;
            r_is_negative  <= n_is_negative;
            r_seen_point   <= n_seen_point;
            r_frac_place   <= n_frac_place;
            r_scan_stopped <= n_scan_stopped;
            r_magnitude    <= n_magnitude;
        end
    end

    // Result register: load on emit, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_target_ready) begin
            r_out_valid <= 1'b0;
        end
        if (emit && out_free) begin
            r_out_value <= emit_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_target_limit;
        end
    end

    assign o_target_valid = r_out_valid;
    assign o_target_value = r_out_value;

endmodule

// ===== rtl/core/sdsp_checker.sv =====
// Port-level checker for the setpoint parser and its bind.
`include "serial_decimal_setpoint_parser_core_defines.svh"

module sdsp_checker
    import sdsp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rx_valid,
    input logic               o_rx_ready,
    input logic [7:0]         i_rx_byte,
    input logic               o_target_valid,
    input logic               i_target_ready,
    input t_value             o_target_value,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [LIMIT_W-1:0] i_cfg_target_limit
);

    logic [LIMIT_W-1:0] r_limit;
    t_value             lim_pos;
    logic               rx_take, rx_eol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_target_limit;
        end
    end

    assign lim_pos = t_value'({1'b0, r_limit});
    assign rx_take = i_rx_valid && o_rx_ready;
    assign rx_eol  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);

    `SDSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_target_valid && !i_target_ready, o_target_valid, "result dropped while stalled")
    `SDSP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_target_valid && !i_target_ready, $stable(o_target_value), "result changed while stalled")
    `SDSP_ASSERT_SAME(a_out_clamped, i_clk, i_rst_n, o_target_valid, (o_target_value <= lim_pos) && (o_target_value >= -lim_pos), "result outside limit")
    `SDSP_ASSERT_SAME(a_out_from_eol, i_clk, i_rst_n, $rose(o_target_valid), $past(rx_take && rx_eol, 2), "result without a terminator word")

endmodule

bind serial_decimal_setpoint_parser_core sdsp_checker u_sdsp_checker (.*);
